### rtl/core/srcc_pkg.sv
// ----------------------------------------------------------------------------
// srcc_pkg: shared types, codes and helpers
// Coordinate widths, sign flags and the side/corner tests used by the
// segment against rectangle boundary counter.
// ----------------------------------------------------------------------------
package srcc_pkg;

  // Widths: coordinate, difference, product of two differences, cross product
  localparam int COORD_WIDTH = 16;
  localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
  localparam int CROSS_WIDTH = PROD_WIDTH + 1;
  localparam int COUNT_WIDTH = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
  typedef logic signed [PROD_WIDTH-1:0]  prod_t;
  typedef logic signed [CROSS_WIDTH-1:0] cross_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;

  // Count reported when the segment runs along a side
  localparam count_t MP_OVERLAP = COUNT_WIDTH'(4);

  // Corner codes: bit 1 selects high x, bit 0 selects high y
  localparam logic [1:0] CNR_LL = 2'b00;
  localparam logic [1:0] CNR_LH = 2'b01;
  localparam logic [1:0] CNR_HL = 2'b10;
  localparam logic [1:0] CNR_HH = 2'b11;

  // Rectangle bound codes: bit 1 selects y, bit 0 selects the high bound
  localparam logic [1:0] BND_XLO = 2'b00;
  localparam logic [1:0] BND_XHI = 2'b01;
  localparam logic [1:0] BND_YLO = 2'b10;
  localparam logic [1:0] BND_YHI = 2'b11;

  // Segment endpoint codes
  localparam logic EP_START = 1'b0;
  localparam logic EP_END   = 1'b1;

  // Three-way sign: neither flag set means zero
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  // Everything the final count needs about one item
  typedef struct packed {
    sgn_t [3:0]       corner_o;  // orientation of each corner against the segment
    logic [1:0][3:0]  lt;        // endpoint coordinate below the bound
    logic [1:0][3:0]  gt;        // endpoint coordinate above the bound
    logic             flat_x;    // zero width
    logic             flat_y;    // zero height
    logic             dx_zero;   // vertical segment
    logic             dy_zero;   // horizontal segment
  } geo_t;

  // {a < b, a > b}
  function automatic logic [1:0] cmp2(coord_t a, coord_t b);
    return {a < b, a > b};
  endfunction

  function automatic sgn_t cross_sign(cross_t v);
    sgn_t s;
    s.neg = v[CROSS_WIDTH-1];
    s.pos = !v[CROSS_WIDTH-1] && (v != '0);
    return s;
  endfunction

  function automatic logic sgn_zero(sgn_t s);
    return !s.pos && !s.neg;
  endfunction

  // Strictly opposite signs
  function automatic logic sgn_opp(sgn_t a, sgn_t b);
    return (a.pos && b.neg) || (a.neg && b.pos);
  endfunction

  function automatic sgn_t sgn_mul(sgn_t a, sgn_t b);
    sgn_t r;
    r.pos = (a.pos && b.pos) || (a.neg && b.neg);
    r.neg = (a.pos && b.neg) || (a.neg && b.pos);
    return r;
  endfunction

  function automatic logic [1:0] x_bnd(logic hi);
    return hi ? BND_XHI : BND_XLO;
  endfunction

  function automatic logic [1:0] y_bnd(logic hi);
    return hi ? BND_YHI : BND_YLO;
  endfunction

  // Sign of (endpoint coordinate - bound)
  function automatic sgn_t bound_sign(geo_t g, logic ep, logic [1:0] bnd);
    sgn_t s;
    s.pos = g.gt[ep][bnd];
    s.neg = g.lt[ep][bnd];
    return s;
  endfunction

  // Sign of one side's step along an axis, from corner a to corner b
  function automatic sgn_t side_dir(logic flat, logic a_hi, logic b_hi);
    sgn_t s;
    s.pos = !flat && b_hi && !a_hi;
    s.neg = !flat && a_hi && !b_hi;
    return s;
  endfunction

  // Orientation of an endpoint against an axis-aligned side a->b.
  // One of the two cross terms is always zero, so the difference of signs
  // is exact.
  function automatic sgn_t orient_side(geo_t g, logic [1:0] ca, logic [1:0] cb,
                                       logic ep);
    sgn_t sx;
    sgn_t sy;
    sgn_t s;
    sgn_t t;
    sgn_t r;
    sx    = side_dir(g.flat_x, ca[1], cb[1]);
    sy    = side_dir(g.flat_y, ca[0], cb[0]);
    s     = sgn_mul(sx, bound_sign(g, ep, y_bnd(ca[0])));
    t     = sgn_mul(sy, bound_sign(g, ep, x_bnd(ca[1])));
    r.pos = s.pos || t.neg;
    r.neg = s.neg || t.pos;
    return r;
  endfunction

  // Endpoint lies inside the bounding box of side a->b
  function automatic logic ep_in_side(geo_t g, logic [1:0] ca, logic [1:0] cb,
                                      logic ep);
    logic [1:0] xmin;
    logic [1:0] xmax;
    logic [1:0] ymin;
    logic [1:0] ymax;
    xmin = x_bnd(ca[1] && cb[1]);
    xmax = x_bnd(ca[1] || cb[1]);
    ymin = y_bnd(ca[0] && cb[0]);
    ymax = y_bnd(ca[0] || cb[0]);
    return !g.lt[ep][xmin] && !g.gt[ep][xmax] && !g.lt[ep][ymin] && !g.gt[ep][ymax];
  endfunction

  // Corner lies inside the bounding box of the segment
  function automatic logic corner_in_seg(geo_t g, logic [1:0] c);
    logic [1:0] bx;
    logic [1:0] by;
    bx = x_bnd(c[1]);
    by = y_bnd(c[0]);
    return !(g.gt[EP_START][bx] && g.gt[EP_END][bx]) &&
           !(g.lt[EP_START][bx] && g.lt[EP_END][bx]) &&
           !(g.gt[EP_START][by] && g.gt[EP_END][by]) &&
           !(g.lt[EP_START][by] && g.lt[EP_END][by]);
  endfunction

  // Corner lies on the closed segment
  function automatic logic corner_on_seg(geo_t g, logic [1:0] c);
    return sgn_zero(g.corner_o[c]) && corner_in_seg(g, c);
  endfunction

  // Closed segment meets the closed side a->b
  function automatic logic meets_side(geo_t g, logic [1:0] ca, logic [1:0] cb);
    sgn_t o1;
    sgn_t o2;
    sgn_t o3;
    sgn_t o4;
    o1 = g.corner_o[ca];
    o2 = g.corner_o[cb];
    o3 = orient_side(g, ca, cb, EP_START);
    o4 = orient_side(g, ca, cb, EP_END);
    return (sgn_opp(o1, o2) && sgn_opp(o3, o4)) ||
           (sgn_zero(o1) && corner_in_seg(g, ca)) ||
           (sgn_zero(o2) && corner_in_seg(g, cb)) ||
           (sgn_zero(o3) && ep_in_side(g, ca, cb, EP_START)) ||
           (sgn_zero(o4) && ep_in_side(g, ca, cb, EP_END));
  endfunction

endpackage

### rtl/core/segment_rectangle_crossing_count.sv
// ----------------------------------------------------------------------------
// segment_rectangle_crossing_count: segment against rectangle boundary
// Counts the distinct points where a segment meets an axis-aligned
// rectangle's boundary, with a flag for a segment lying along a side.
// Throughput: one item per cycle; the whole pipe holds while a result waits.
// Stages: corner sort and differences, products and compares, cross signs,
// count into the output register.
// Reset: rst_n (synchronous) clears the stage valid bits only.
// ----------------------------------------------------------------------------
module segment_rectangle_crossing_count (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [srcc_pkg::COORD_WIDTH-1:0] in_rect_left,
  input  logic signed [srcc_pkg::COORD_WIDTH-1:0] in_rect_bottom,
  input  logic signed [srcc_pkg::COORD_WIDTH-1:0] in_rect_right,
  input  logic signed [srcc_pkg::COORD_WIDTH-1:0] in_rect_top,
  input  logic signed [srcc_pkg::COORD_WIDTH-1:0] in_start_x,
  input  logic signed [srcc_pkg::COORD_WIDTH-1:0] in_start_y,
  input  logic signed [srcc_pkg::COORD_WIDTH-1:0] in_end_x,
  input  logic signed [srcc_pkg::COORD_WIDTH-1:0] in_end_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [srcc_pkg::COUNT_WIDTH-1:0]     out_meeting_points,
  output logic                                 out_overlaps_side
);

  import srcc_pkg::*;

  // Pipe control: every stage moves together
  logic   advance;

  // Stage 1: sorted rectangle, endpoints and differences
  logic   s1_valid_r;
  coord_t s1_xlo_r, s1_xhi_r, s1_ylo_r, s1_yhi_r;
  coord_t s1_sx_r, s1_sy_r, s1_ex_r, s1_ey_r;
  diff_t  s1_dx_r, s1_dy_r;
  diff_t  s1_ox_lo_r, s1_ox_hi_r, s1_oy_lo_r, s1_oy_hi_r;
  logic   swap_x, swap_y;
  diff_t  dx_nxt, dy_nxt;
  diff_t  ox_a, ox_b, oy_a, oy_b;

  // Stage 2: partial products and endpoint/bound compares
  logic            s2_valid_r;
  prod_t           s2_pdx_ylo_r, s2_pdx_yhi_r, s2_pdy_xlo_r, s2_pdy_xhi_r;
  logic [1:0][3:0] s2_lt_r, s2_gt_r;
  logic [1:0][3:0] s2_lt_nxt, s2_gt_nxt;
  logic            s2_flat_x_r, s2_flat_y_r, s2_dx_zero_r, s2_dy_zero_r;

  // Stage 3: corner orientation signs with the compare flags
  logic   s3_valid_r;
  geo_t   s3_geo_r;
  geo_t   s3_geo_nxt;

  // Stage 4: output register
  logic   out_valid_r;
  count_t out_meeting_points_r;
  logic   out_overlaps_side_r;
  count_t mp_nxt;
  logic   ov_nxt;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = !advance;
  assign out_valid = out_valid_r;
  assign out_meeting_points = out_meeting_points_r;
  assign out_overlaps_side  = out_overlaps_side_r;

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  // Stage 1 logic: sort corners, offsets chosen by the same compare
  always_comb begin
    swap_x = in_rect_left > in_rect_right;
    swap_y = in_rect_bottom > in_rect_top;
    dx_nxt = diff_t'(in_end_x) - diff_t'(in_start_x);
    dy_nxt = diff_t'(in_end_y) - diff_t'(in_start_y);
    ox_a   = diff_t'(in_rect_left) - diff_t'(in_start_x);
    ox_b   = diff_t'(in_rect_right) - diff_t'(in_start_x);
    oy_a   = diff_t'(in_rect_bottom) - diff_t'(in_start_y);
    oy_b   = diff_t'(in_rect_top) - diff_t'(in_start_y);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_xlo_r   <= swap_x ? in_rect_right : in_rect_left;
      s1_xhi_r   <= swap_x ? in_rect_left : in_rect_right;
      s1_ylo_r   <= swap_y ? in_rect_top : in_rect_bottom;
      s1_yhi_r   <= swap_y ? in_rect_bottom : in_rect_top;
      s1_sx_r    <= in_start_x;
      s1_sy_r    <= in_start_y;
      s1_ex_r    <= in_end_x;
      s1_ey_r    <= in_end_y;
      s1_dx_r    <= dx_nxt;
      s1_dy_r    <= dy_nxt;
      s1_ox_lo_r <= swap_x ? ox_b : ox_a;
      s1_ox_hi_r <= swap_x ? ox_a : ox_b;
      s1_oy_lo_r <= swap_y ? oy_b : oy_a;
      s1_oy_hi_r <= swap_y ? oy_a : oy_b;
    end
  end

  // Stage 2 logic: endpoint coordinates against each rectangle bound
  always_comb begin
    s2_lt_nxt = '0;
    s2_gt_nxt = '0;
    {s2_lt_nxt[EP_START][BND_XLO], s2_gt_nxt[EP_START][BND_XLO]} = cmp2(s1_sx_r, s1_xlo_r);
    {s2_lt_nxt[EP_START][BND_XHI], s2_gt_nxt[EP_START][BND_XHI]} = cmp2(s1_sx_r, s1_xhi_r);
    {s2_lt_nxt[EP_START][BND_YLO], s2_gt_nxt[EP_START][BND_YLO]} = cmp2(s1_sy_r, s1_ylo_r);
    {s2_lt_nxt[EP_START][BND_YHI], s2_gt_nxt[EP_START][BND_YHI]} = cmp2(s1_sy_r, s1_yhi_r);
    {s2_lt_nxt[EP_END][BND_XLO], s2_gt_nxt[EP_END][BND_XLO]}     = cmp2(s1_ex_r, s1_xlo_r);
    {s2_lt_nxt[EP_END][BND_XHI], s2_gt_nxt[EP_END][BND_XHI]}     = cmp2(s1_ex_r, s1_xhi_r);
    {s2_lt_nxt[EP_END][BND_YLO], s2_gt_nxt[EP_END][BND_YLO]}     = cmp2(s1_ey_r, s1_ylo_r);
    {s2_lt_nxt[EP_END][BND_YHI], s2_gt_nxt[EP_END][BND_YHI]}     = cmp2(s1_ey_r, s1_yhi_r);
  end

  // Products for cross(corner) = dx*(cy - y1) - dy*(cx - x1)
  always_ff @(posedge clk) begin
    if (advance) begin
      s2_pdx_ylo_r <= prod_t'(s1_dx_r) * prod_t'(s1_oy_lo_r);
      s2_pdx_yhi_r <= prod_t'(s1_dx_r) * prod_t'(s1_oy_hi_r);
      s2_pdy_xlo_r <= prod_t'(s1_dy_r) * prod_t'(s1_ox_lo_r);
      s2_pdy_xhi_r <= prod_t'(s1_dy_r) * prod_t'(s1_ox_hi_r);
      s2_lt_r      <= s2_lt_nxt;
      s2_gt_r      <= s2_gt_nxt;
      s2_flat_x_r  <= s1_xlo_r == s1_xhi_r;
      s2_flat_y_r  <= s1_ylo_r == s1_yhi_r;
      s2_dx_zero_r <= s1_dx_r == '0;
      s2_dy_zero_r <= s1_dy_r == '0;
    end
  end

  // Stage 3 logic: finish the cross products, keep only their signs
  always_comb begin
    s3_geo_nxt.corner_o[CNR_LL] =
      cross_sign(cross_t'(s2_pdx_ylo_r) - cross_t'(s2_pdy_xlo_r));
    s3_geo_nxt.corner_o[CNR_LH] =
      cross_sign(cross_t'(s2_pdx_yhi_r) - cross_t'(s2_pdy_xlo_r));
    s3_geo_nxt.corner_o[CNR_HL] =
      cross_sign(cross_t'(s2_pdx_ylo_r) - cross_t'(s2_pdy_xhi_r));
    s3_geo_nxt.corner_o[CNR_HH] =
      cross_sign(cross_t'(s2_pdx_yhi_r) - cross_t'(s2_pdy_xhi_r));
    s3_geo_nxt.lt      = s2_lt_r;
    s3_geo_nxt.gt      = s2_gt_r;
    s3_geo_nxt.flat_x  = s2_flat_x_r;
    s3_geo_nxt.flat_y  = s2_flat_y_r;
    s3_geo_nxt.dx_zero = s2_dx_zero_r;
    s3_geo_nxt.dy_zero = s2_dy_zero_r;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_geo_r <= s3_geo_nxt;
    end
  end

  // Stage 4 logic: overlap test, side hits less corners on the segment, or the single span of a degenerate rectangle
  always_comb begin
    logic   on_vert;
    logic   on_horz;
    logic   span_y;
    logic   span_x;
    count_t hits;
    count_t dups;
    on_vert = (!s3_geo_r.lt[EP_START][BND_XLO] && !s3_geo_r.gt[EP_START][BND_XLO]) ||
              (!s3_geo_r.lt[EP_START][BND_XHI] && !s3_geo_r.gt[EP_START][BND_XHI]);
    on_horz = (!s3_geo_r.lt[EP_START][BND_YLO] && !s3_geo_r.gt[EP_START][BND_YLO]) ||
              (!s3_geo_r.lt[EP_START][BND_YHI] && !s3_geo_r.gt[EP_START][BND_YHI]);
    span_y  = !s3_geo_r.dy_zero && !s3_geo_r.flat_y &&
              (s3_geo_r.lt[EP_START][BND_YHI] || s3_geo_r.lt[EP_END][BND_YHI]) &&
              (s3_geo_r.gt[EP_START][BND_YLO] || s3_geo_r.gt[EP_END][BND_YLO]);
    span_x  = !s3_geo_r.dx_zero && !s3_geo_r.flat_x &&
              (s3_geo_r.lt[EP_START][BND_XHI] || s3_geo_r.lt[EP_END][BND_XHI]) &&
              (s3_geo_r.gt[EP_START][BND_XLO] || s3_geo_r.gt[EP_END][BND_XLO]);
    ov_nxt  = (s3_geo_r.dx_zero && on_vert && span_y) ||
              (s3_geo_r.dy_zero && on_horz && span_x);

    hits = count_t'(meets_side(s3_geo_r, CNR_LL, CNR_LH)) +
           count_t'(meets_side(s3_geo_r, CNR_LH, CNR_HH)) +
           count_t'(meets_side(s3_geo_r, CNR_HH, CNR_HL)) +
           count_t'(meets_side(s3_geo_r, CNR_HL, CNR_LL));
    dups = count_t'(corner_on_seg(s3_geo_r, CNR_LL)) +
           count_t'(corner_on_seg(s3_geo_r, CNR_LH)) +
           count_t'(corner_on_seg(s3_geo_r, CNR_HH)) +
           count_t'(corner_on_seg(s3_geo_r, CNR_HL));

    if (ov_nxt) begin
      mp_nxt = MP_OVERLAP;
    end else if (s3_geo_r.flat_x || s3_geo_r.flat_y) begin
      // degenerate rectangle: boundary is the single span low corner to high
      mp_nxt = count_t'(meets_side(s3_geo_r, CNR_LL, CNR_HH));
    end else begin
      mp_nxt = hits - dups;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_meeting_points_r <= mp_nxt;
      out_overlaps_side_r  <= ov_nxt;
    end
  end

endmodule
